@@ design/fhcf_pkg.sv @@
// ----------------------------------------------------------------------------
// fhcf_pkg
// shared constants and the item type passed from front end to back end
// ----------------------------------------------------------------------------
package fhcf_pkg;

  localparam int FHCF_ROW_WIDTH   = 80;
  localparam int FHCF_QUEUE_DEPTH = 4;
  localparam int FHCF_QPTR_W      = $clog2(FHCF_QUEUE_DEPTH);
  localparam int FHCF_QCNT_W      = $clog2(FHCF_QUEUE_DEPTH + 1);
  localparam int FHCF_SUM_W       = 11;
  localparam int FHCF_SHIFT       = 3;

  localparam logic [7:0] FHCF_DECAY_RESET = 8'd3;
  localparam logic [1:0] FHCF_ROWS_NONE   = 2'd0;
  localparam logic [1:0] FHCF_ROWS_FULL   = 2'd2;

  // one accepted pixel with its column data from the line memory
  typedef struct packed {
    logic [7:0] heat;
    logic [7:0] below;
    logic [7:0] two_below;
    logic       col_zero;
    logic       last;
    logic [1:0] rows_seen;
  } fhcf_item_t;

endpackage

@@ design/fire_heat_cooling_filter.sv @@
// ----------------------------------------------------------------------------
// fire_heat_cooling_filter
// streaming cooling filter for a fire heat map
// ----------------------------------------------------------------------------
// Heat pixels enter one item per clock in raster order, bottom row first,
// frame_start marking the first pixel of the bottom row. Each result is the
// sum of eight neighbors (left and right in the same row, three in each of
// the two rows beneath), shifted right by three, minus decay, clamped at
// zero; off-frame neighbors count as zero. Results trail the input by one
// pixel: a row's first item gives none, its last item gives two, the second
// flagged with row_end. The input takes one item per clock while the queue
// has room. The back end gives no result for a row's first item and two for
// its last, so with an unbroken stream and the output always ready the queue
// fills, after which the input stalls while the queue is full. The item that
// completes a result passes the line memory read at its accept edge, then
// the queue write, then the output register, where the result shows; a
// busy output holds it in the queue. Two line buffers share one
// ROW_WIDTH x 16 memory with at most one write and one read each clock; its
// content is undefined after reset and is never used before being refilled,
// so there is no clearing pass. decay (reset 3) is to be written only while
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module fire_heat_cooling_filter #(
  parameter int ROW_WIDTH = fhcf_pkg::FHCF_ROW_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  // pixel input
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] heat_in,
  input  logic       frame_start,
  // result output
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] cooled_heat,
  output logic       row_end,
  // decay register write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import fhcf_pkg::*;

  logic [7:0]             decay;
  logic                   push;
  fhcf_item_t             push_item;
  logic                   pop;
  fhcf_item_t             head_item;
  logic [FHCF_QCNT_W-1:0] q_count;
  logic                   head_valid;

  // register writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay <= FHCF_DECAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      decay <= cfg_data;
    end
  end

  // front end: column and row tracking, line memory read and write-back
  fhcf_front #(
    .ROW_WIDTH (ROW_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .heat_in     (heat_in),
    .frame_start (frame_start),
    .q_count     (q_count),
    .push        (push),
    .push_item   (push_item)
  );

  // decouples pixel acceptance from result back-pressure
  fhcf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .count     (q_count)
  );

  assign head_valid = (q_count != '0);

  // back end: neighbor window, sum, decay, output register
  fhcf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .decay       (decay),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cooled_heat (cooled_heat),
    .row_end     (row_end)
  );

endmodule

@@ design/fhcf_front.sv @@
// ----------------------------------------------------------------------------
// fhcf_front
// accepts pixels, tracks column and row count, owns the line memory
// ----------------------------------------------------------------------------
module fhcf_front #(
  parameter int ROW_WIDTH = fhcf_pkg::FHCF_ROW_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       heat_in,
  input  logic                             frame_start,
  input  logic [fhcf_pkg::FHCF_QCNT_W-1:0] q_count,
  output logic                             push,
  output fhcf_pkg::fhcf_item_t             push_item
);
  import fhcf_pkg::*;

  localparam int AddrW = $clog2(ROW_WIDTH);
  localparam logic [AddrW-1:0] LastCol = AddrW'(ROW_WIDTH - 1);

  // word is {row two below, row below}
  logic [15:0] line_mem [ROW_WIDTH];
  logic [15:0] mem_q;

  logic [AddrW-1:0] column;
  logic [1:0]       rows_seen;
  logic             prev_was_last;
  logic [7:0]       prev_pixel;
  logic [7:0]       rd_hold;
  logic             f1_valid;
  logic [7:0]       f1_heat;
  logic             f1_col_zero;
  logic             f1_last;
  logic [1:0]       f1_rows;

  logic             accept;
  logic [AddrW-1:0] cur_col;
  logic             cur_last;
  logic [1:0]       cur_rows;
  logic [1:0]       rows_next;
  logic [AddrW-1:0] column_next;
  logic [7:0]       old_below;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;

  // reserve a queue slot for the item still waiting on memory data
  assign in_ready = (q_count + FHCF_QCNT_W'(f1_valid)) < FHCF_QCNT_W'(FHCF_QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cur_col     = frame_start ? '0 : column;
    cur_rows    = frame_start ? FHCF_ROWS_NONE : rows_seen;
    cur_last    = (cur_col == LastCol);
    column_next = cur_last ? '0 : cur_col + AddrW'(1);
    rows_next   = (cur_last && (cur_rows != FHCF_ROWS_FULL)) ? cur_rows + 2'd1 : cur_rows;
    // below value of the previous column, read by the previous item
    old_below   = f1_valid ? mem_q[7:0] : rd_hold;
    // previous column goes back one row; row end is flushed by the next row's first item
    wr_en       = accept && ((cur_col != '0) || prev_was_last);
    wr_addr     = (cur_col == '0) ? LastCol : cur_col - AddrW'(1);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= {old_below, prev_pixel};
    end
    if (accept) begin
      mem_q <= line_mem[cur_col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column        <= '0;
      rows_seen     <= FHCF_ROWS_NONE;
      prev_was_last <= 1'b0;
      f1_valid      <= 1'b0;
    end else begin
      f1_valid <= accept;
      if (accept) begin
        column        <= column_next;
        rows_seen     <= rows_next;
        prev_was_last <= cur_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_pixel  <= heat_in;
      f1_heat     <= heat_in;
      f1_col_zero <= (cur_col == '0);
      f1_last     <= cur_last;
      f1_rows     <= cur_rows;
    end
    if (f1_valid) begin
      rd_hold <= mem_q[7:0];
    end
  end

  assign push = f1_valid;

  always_comb begin
    push_item.heat      = f1_heat;
    push_item.below     = mem_q[7:0];
    push_item.two_below = mem_q[15:8];
    push_item.col_zero  = f1_col_zero;
    push_item.last      = f1_last;
    push_item.rows_seen = f1_rows;
  end

endmodule

@@ design/fhcf_queue.sv @@
// ----------------------------------------------------------------------------
// fhcf_queue
// short fifo between front end and back end
// ----------------------------------------------------------------------------
module fhcf_queue (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  fhcf_pkg::fhcf_item_t             push_item,
  input  logic                             pop,
  output fhcf_pkg::fhcf_item_t             head_item,
  output logic [fhcf_pkg::FHCF_QCNT_W-1:0] count
);
  import fhcf_pkg::*;

  fhcf_item_t             entries [FHCF_QUEUE_DEPTH];
  logic [FHCF_QPTR_W-1:0] wr_ptr;
  logic [FHCF_QPTR_W-1:0] rd_ptr;

  assign head_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FHCF_QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FHCF_QPTR_W'(1);
      end
      count <= count + FHCF_QCNT_W'(push) - FHCF_QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < FHCF_QCNT_W'(FHCF_QUEUE_DEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue pop while empty");

endmodule

@@ design/fhcf_back.sv @@
// ----------------------------------------------------------------------------
// fhcf_back
// neighbor window, eight-tap sum, decay and the output register
// ----------------------------------------------------------------------------
module fhcf_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             head_valid,
  input  fhcf_pkg::fhcf_item_t             head_item,
  input  logic [7:0]                       decay,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       cooled_heat,
  output logic                             row_end
);
  import fhcf_pkg::*;

  // window: index 1 is the previous column, index 0 the one before it
  logic [7:0] p0, p1;
  logic [7:0] r0, r1;
  logic [7:0] s0, s1;
  logic       phase;
  logic       phase_next;

  logic                  b_ok, t_ok;
  logic [7:0]            bm0, bm1, bmn, tm0, tm1, tmn;
  logic [FHCF_SUM_W-1:0] sum_first, sum_second, sum_sel;
  logic [7:0]            avg;
  logic [7:0]            result;
  logic                  can_load;
  logic                  load;

  always_comb begin
    b_ok = (head_item.rows_seen != FHCF_ROWS_NONE);
    t_ok = (head_item.rows_seen == FHCF_ROWS_FULL);
    bm0  = b_ok ? r0 : 8'd0;
    bm1  = b_ok ? r1 : 8'd0;
    bmn  = b_ok ? head_item.below : 8'd0;
    tm0  = t_ok ? s0 : 8'd0;
    tm1  = t_ok ? s1 : 8'd0;
    tmn  = t_ok ? head_item.two_below : 8'd0;
    // pixel left of the latest input
    sum_first  = FHCF_SUM_W'(p0) + FHCF_SUM_W'(head_item.heat)
               + FHCF_SUM_W'(bm0) + FHCF_SUM_W'(bm1) + FHCF_SUM_W'(bmn)
               + FHCF_SUM_W'(tm0) + FHCF_SUM_W'(tm1) + FHCF_SUM_W'(tmn);
    // last pixel of the row, right side off the frame
    sum_second = FHCF_SUM_W'(p1)
               + FHCF_SUM_W'(bm1) + FHCF_SUM_W'(bmn)
               + FHCF_SUM_W'(tm1) + FHCF_SUM_W'(tmn);
    sum_sel = phase ? sum_second : sum_first;
    avg     = sum_sel[FHCF_SUM_W-1:FHCF_SHIFT];
    result  = (avg > decay) ? avg - decay : 8'd0;
  end

  assign can_load = !out_valid || out_ready;

  always_comb begin
    pop        = 1'b0;
    load       = 1'b0;
    phase_next = phase;
    if (head_valid) begin
      priority if (phase) begin
        if (can_load) begin
          load       = 1'b1;
          pop        = 1'b1;
          phase_next = 1'b0;
        end
      end else if (head_item.col_zero) begin
        pop = 1'b1;
      end else begin
        if (can_load) begin
          load = 1'b1;
          if (head_item.last) begin
            phase_next = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cooled_heat <= result;
      row_end     <= phase;
    end
    if (pop) begin
      p0 <= head_item.col_zero ? 8'd0 : p1;
      p1 <= head_item.heat;
      r0 <= head_item.col_zero ? 8'd0 : r1;
      r1 <= head_item.below;
      s0 <= head_item.col_zero ? 8'd0 : s1;
      s1 <= head_item.two_below;
    end
  end

  a_phase_on_row_end: assert property (@(posedge clk) disable iff (rst)
    phase |-> (head_valid && head_item.last))
    else $error("second result pending without a row-end item");

  a_pop_after_result: assert property (@(posedge clk) disable iff (rst)
    (pop && !head_item.col_zero) |-> load)
    else $error("item dropped before its result was loaded");

endmodule
